// ===== rtl/core/tgr_pkg.sv =====
// tgr_pkg: shared types, constants and elaboration-time functions for the
// tilt gravity removal block (sine table builder, saturation helper)
// no dependencies

package tgr_pkg;

   // default sine table resolution over one quarter wave
   localparam int SINE_TABLE_DEPTH_DEFAULT = 256;

   // angle units are hundredths of a degree
   localparam int ANGLE_FULL     = 36000;
   localparam int ANGLE_QUARTER  = 9000;
   localparam int ANGLE_HALF     = 18000;
   localparam int ANGLE_3QUARTER = 27000;
   localparam int INDEX_ROUND    = 4500;

   // pipeline depth: angle lookup stages plus product, round and sum stages
   localparam int LU_STAGES   = 7;
   localparam int POST_STAGES = 4;
   localparam int LATENCY     = LU_STAGES + POST_STAGES;

   // register file
   localparam int CSR_ADDR_W = 4;
   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_GRAVITY = 2'd0;
   localparam reg_index_type REG_FF_LOW  = 2'd1;
   localparam reg_index_type REG_FF_HIGH = 2'd2;

   localparam logic [14:0]        GRAVITY_RESET = 15'd10042;
   localparam logic signed [15:0] FF_LOW_RESET  = -16'sd2048;
   localparam logic signed [15:0] FF_HIGH_RESET = 16'sd5120;

   // q30 series constants for the sine table
   localparam longint Q30_ONE      = 64'sd1073741824;
   localparam longint HALF_PI_Q30  = 64'sd1686629713;
   localparam int     SERIES_TERMS = 7;
   localparam longint SERIES_DIV [SERIES_TERMS] = '{6, 20, 42, 72, 110, 156, 210};

   // measured values that ride along with the angle lookups
   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic               free_fall;
   } side_type;

   // sine of a q30 angle in q1.15, rounded to nearest and capped
   function automatic logic [14:0] sine_q15(input longint x);
      longint term;
      longint sum;
      longint v;
      int     n;
      term = x;
      sum  = x;
      for (n = 0; n < SERIES_TERMS; n++) begin
         term = term * x / Q30_ONE;
         term = term * x / Q30_ONE;
         term = term / SERIES_DIV[n];
         term = -term;
         sum  = sum + term;
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (sum + 64'sd16384) / 64'sd32768;
      if (v > 64'sd32767) begin
         v = 64'sd32767;
      end
      return 15'(v);
   endfunction

   // clamp an 18 bit sum to signed 16 bits
   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/tgr_sine_lookup.sv =====
// tgr_sine_lookup: seven stage table sine of an angle in hundredths of a degree
// depends on tgr_pkg (angle constants, sine table builder)

module tgr_sine_lookup #(
   parameter int DEPTH = tgr_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic signed [16:0] angle,
   output logic signed [15:0] sine
);

   localparam int IDX_W   = $clog2(DEPTH + 1);
   localparam int N_MAX   = (tgr_pkg::ANGLE_QUARTER - 1) * DEPTH + tgr_pkg::INDEX_ROUND;
   localparam int N_W     = $clog2(N_MAX + 1);
   // floor reciprocal of the quarter; the quotient it gives is low by at most one
   localparam int RECIP   = (1 << N_W) / tgr_pkg::ANGLE_QUARTER;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = N_W + RECIP_W;

   localparam logic signed [16:0] FULL_S = 17'(tgr_pkg::ANGLE_FULL);
   localparam logic [15:0] Q1 = 16'(tgr_pkg::ANGLE_QUARTER);
   localparam logic [15:0] Q2 = 16'(tgr_pkg::ANGLE_HALF);
   localparam logic [15:0] Q3 = 16'(tgr_pkg::ANGLE_3QUARTER);

   // constant quarter wave table
   logic [14:0] sine_rom [DEPTH + 1];

   for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
      localparam longint XQ = tgr_pkg::HALF_PI_Q30 * longint'(k) / DEPTH;
      assign sine_rom[k] = tgr_pkg::sine_q15(XQ);
   end

   logic [15:0]        a_ff, a_in;
   logic [1:0]         quad2_ff, quad2_in;
   logic [13:0]        r_ff, r_in;
   logic [1:0]         quad3_ff;
   logic [N_W-1:0]     n3_ff, n3_in;
   logic [1:0]         quad4_ff;
   logic [N_W-1:0]     n4_ff;
   logic [IDX_W-1:0]   q0_ff, q0_in;
   logic [PROD_W-1:0]  prod;
   logic [1:0]         quad5_ff;
   logic [N_W-1:0]     rem;
   logic [IDX_W-1:0]   q5_ff, q5_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic               neg_ff, neg_in;
   logic signed [15:0] sine_ff, sine_in;

   // stage 1: wrap into one turn
   always_comb begin
      if (angle < 17'sd0) begin
         a_in = 16'(angle + FULL_S);
      end else if (angle >= FULL_S) begin
         a_in = 16'(angle - FULL_S);
      end else begin
         a_in = 16'(angle);
      end
   end

   // stage 2: quadrant and remainder
   always_comb begin
      priority if (a_ff >= Q3) begin
         quad2_in = 2'd3;
         r_in     = 14'(a_ff - Q3);
      end else if (a_ff >= Q2) begin
         quad2_in = 2'd2;
         r_in     = 14'(a_ff - Q2);
      end else if (a_ff >= Q1) begin
         quad2_in = 2'd1;
         r_in     = 14'(a_ff - Q1);
      end else begin
         quad2_in = 2'd0;
         r_in     = 14'(a_ff);
      end
   end

   // stage 3: scale the remainder to table steps with rounding offset
   assign n3_in = N_W'(r_ff) * N_W'(DEPTH) + N_W'(tgr_pkg::INDEX_ROUND);

   // stage 4: quotient estimate through the reciprocal
   assign prod  = PROD_W'(n3_ff) * PROD_W'(RECIP);
   assign q0_in = IDX_W'(prod >> N_W);

   // stage 5: one correction step
   assign rem   = n4_ff - N_W'(q0_ff) * N_W'(tgr_pkg::ANGLE_QUARTER);
   assign q5_in = (rem >= N_W'(tgr_pkg::ANGLE_QUARTER)) ? q0_ff + IDX_W'(1) : q0_ff;

   // stage 6: mirror the index in the odd quadrants, negate in the lower half
   assign addr_in = quad5_ff[0] ? IDX_W'(DEPTH) - q5_ff : q5_ff;
   assign neg_in  = quad5_ff[1];

   // stage 7: table read
   always_comb begin
      if (neg_ff) begin
         sine_in = -$signed({1'b0, sine_rom[addr_ff]});
      end else begin
         sine_in = $signed({1'b0, sine_rom[addr_ff]});
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      quad2_ff <= quad2_in;
      r_ff     <= r_in;
      quad3_ff <= quad2_ff;
      n3_ff    <= n3_in;
      quad4_ff <= quad3_ff;
      n4_ff    <= n3_ff;
      q0_ff    <= q0_in;
      quad5_ff <= quad4_ff;
      q5_ff    <= q5_in;
      addr_ff  <= addr_in;
      neg_ff   <= neg_in;
      sine_ff  <= sine_in;
   end

   assign sine = sine_ff;

endmodule

// ===== rtl/core/tilt_gravity_removal.sv =====
// tilt_gravity_removal: adds the tilt gravity vector to a measured acceleration
// depends on tgr_pkg and tgr_sine_lookup
//
// Usage:
//   Input words are taken at a rising edge with start high and busy low. Each
//   word carries roll and pitch in hundredths of a degree and three measured
//   acceleration axes. The block looks up sine and cosine of both angles,
//   forms g*sin(roll), -g*sin(pitch)*cos(roll), -g*cos(pitch)*cos(roll),
//   adds them to the measured axes with 16 bit saturation and flags free fall
//   when accel_z lies strictly between the two thresholds.
//   Throughput is one word per clock while busy is low. Each word yields one
//   result word on the rsp_ ports, marked by rsp_valid for one cycle; it passes
//   through 7 stages in the angle lookup (wrap, quadrant, scale, reciprocal
//   multiply, correction, mirror, table read) and 4 after it (angle products,
//   gravity products, rounding, sum and clamp).
//   The receiver cannot stall, so results are never held back.
//   Reset clears the pipeline valids and loads the register defaults; busy is
//   high for the cycle after a reset edge and low otherwise.
//   Registers over the apb port: 0x0 gravity_magnitude, 0x4 free_fall_low,
//   0x8 free_fall_high; write only while no word is in flight.

module tilt_gravity_removal #(
   parameter int SINE_TABLE_DEPTH = tgr_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [15:0]              req_roll_angle,
   input  logic signed [15:0]              req_pitch_angle,
   input  logic signed [15:0]              req_accel_x,
   input  logic signed [15:0]              req_accel_y,
   input  logic signed [15:0]              req_accel_z,
   output logic                            rsp_valid,
   output logic signed [15:0]              rsp_linear_x,
   output logic signed [15:0]              rsp_linear_y,
   output logic signed [15:0]              rsp_linear_z,
   output logic                            rsp_free_fall,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tgr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int LAT = tgr_pkg::LATENCY;
   localparam int LUS = tgr_pkg::LU_STAGES;

   // configuration registers
   logic [14:0]        grav_ff, grav_in;
   logic signed [15:0] ff_low_ff, ff_low_in;
   logic signed [15:0] ff_high_ff, ff_high_in;
   logic               busy_ff;
   logic               accept;
   logic               wr_en;
   tgr_pkg::reg_index_type reg_idx;

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // register writes
   always_comb begin
      grav_in    = grav_ff;
      ff_low_in  = ff_low_ff;
      ff_high_in = ff_high_ff;
      if (wr_en) begin
         unique case (reg_idx)
            tgr_pkg::REG_GRAVITY: grav_in    = pwdata[14:0];
            tgr_pkg::REG_FF_LOW:  ff_low_in  = $signed(pwdata[15:0]);
            tgr_pkg::REG_FF_HIGH: ff_high_in = $signed(pwdata[15:0]);
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (reg_idx)
         tgr_pkg::REG_GRAVITY: prdata = {17'd0, grav_ff};
         tgr_pkg::REG_FF_LOW:  prdata = {{16{ff_low_ff[15]}}, ff_low_ff};
         tgr_pkg::REG_FF_HIGH: prdata = {{16{ff_high_ff[15]}}, ff_high_ff};
         default:              prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff    <= tgr_pkg::GRAVITY_RESET;
         ff_low_ff  <= tgr_pkg::FF_LOW_RESET;
         ff_high_ff <= tgr_pkg::FF_HIGH_RESET;
         busy_ff    <= 1'b1;
      end else begin
         grav_ff    <= grav_in;
         ff_low_ff  <= ff_low_in;
         ff_high_ff <= ff_high_in;
         busy_ff    <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // valid bits travel with the word
   logic [LAT-1:0] vld_ff, vld_in;
   assign vld_in = {vld_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // angle lookups, cosine as the sine a quarter turn ahead
   logic signed [15:0] sr, cr, sp, cp;

   tgr_sine_lookup #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_roll (
      .clock (clock),
      .angle (17'(req_roll_angle)),
      .sine  (sr)
   );

   tgr_sine_lookup #(.DEPTH(SINE_TABLE_DEPTH)) u_cos_roll (
      .clock (clock),
      .angle (17'(req_roll_angle) + 17'(tgr_pkg::ANGLE_QUARTER)),
      .sine  (cr)
   );

   tgr_sine_lookup #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_pitch (
      .clock (clock),
      .angle (17'(req_pitch_angle)),
      .sine  (sp)
   );

   tgr_sine_lookup #(.DEPTH(SINE_TABLE_DEPTH)) u_cos_pitch (
      .clock (clock),
      .angle (17'(req_pitch_angle) + 17'(tgr_pkg::ANGLE_QUARTER)),
      .sine  (cp)
   );

   // measured axes and free fall flag follow the lookups
   tgr_pkg::side_type side_in;
   tgr_pkg::side_type side_ff [LUS];

   always_comb begin
      side_in.ax        = req_accel_x;
      side_in.ay        = req_accel_y;
      side_in.az        = req_accel_z;
      side_in.free_fall = (req_accel_z > ff_low_ff) && (req_accel_z < ff_high_ff);
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int i = 1; i < LUS; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   logic signed [15:0] g_s;
   assign g_s = $signed({1'b0, grav_ff});

   // angle products and the x gravity product
   logic signed [31:0] gx_prod_ff, gx_prod_in;
   logic signed [31:0] ycos_ff, ycos_in;
   logic signed [31:0] zcos_ff, zcos_in;
   tgr_pkg::side_type  side8_ff;

   assign gx_prod_in = g_s * sr;
   assign ycos_in    = sp * cr;
   assign zcos_in    = cp * cr;

   // gravity products, x rounded
   logic signed [47:0] wy_ff, wy_in;
   logic signed [47:0] wz_ff, wz_in;
   logic signed [16:0] gx9_ff, gx9_in;
   tgr_pkg::side_type  side9_ff;

   assign wy_in  = g_s * ycos_ff;
   assign wz_in  = g_s * zcos_ff;
   assign gx9_in = 17'((gx_prod_ff + (gx_prod_ff[31] ? 32'sd16383 : 32'sd16384)) >>> 15);

   // y and z rounded, ties away from zero, and negated
   logic signed [16:0] gx10_ff;
   logic signed [16:0] gy_ff, gy_in;
   logic signed [16:0] gz_ff, gz_in;
   tgr_pkg::side_type  side10_ff;

   assign gy_in = -17'((wy_ff + (wy_ff[47] ? 48'sd536870911 : 48'sd536870912)) >>> 30);
   assign gz_in = -17'((wz_ff + (wz_ff[47] ? 48'sd536870911 : 48'sd536870912)) >>> 30);

   // sums with saturation into the output word
   logic signed [15:0] lin_x_ff, lin_x_in;
   logic signed [15:0] lin_y_ff, lin_y_in;
   logic signed [15:0] lin_z_ff, lin_z_in;
   logic               ffall_ff;

   assign lin_x_in = tgr_pkg::sat16(18'(side10_ff.ax) + 18'(gx10_ff));
   assign lin_y_in = tgr_pkg::sat16(18'(side10_ff.ay) + 18'(gy_ff));
   assign lin_z_in = tgr_pkg::sat16(18'(side10_ff.az) + 18'(gz_ff));

   always_ff @(posedge clock) begin
      gx_prod_ff <= gx_prod_in;
      ycos_ff    <= ycos_in;
      zcos_ff    <= zcos_in;
      side8_ff   <= side_ff[LUS-1];
      wy_ff      <= wy_in;
      wz_ff      <= wz_in;
      gx9_ff     <= gx9_in;
      side9_ff   <= side8_ff;
      gx10_ff    <= gx9_ff;
      gy_ff      <= gy_in;
      gz_ff      <= gz_in;
      side10_ff  <= side9_ff;
      lin_x_ff   <= lin_x_in;
      lin_y_ff   <= lin_y_in;
      lin_z_ff   <= lin_z_in;
      ffall_ff   <= side10_ff.free_fall;
   end

   assign rsp_valid     = vld_ff[LAT-1];
   assign rsp_linear_x  = lin_x_ff;
   assign rsp_linear_y  = lin_y_ff;
   assign rsp_linear_z  = lin_z_ff;
   assign rsp_free_fall = ffall_ff;

endmodule

// ===== rtl/core/tgr_checker.sv =====
// tgr_checker: port level checks on the tilt gravity removal block, bound to it
// depends on tgr_pkg (latency) and tilt_gravity_removal

module tgr_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic pready
);

   localparam int LAT = tgr_pkg::LATENCY;

   // every taken word gives a result after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("taken word gave no result");

   // no result without a word taken the fixed latency before
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without a taken word");

   // busy only in the cycle after a reset edge
   a_busy_reset: assert property (@(posedge clock)
      1'b1 |=> (busy == $past(reset)))
      else $error("busy does not follow reset");

   // configuration port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind tilt_gravity_removal tgr_checker u_tgr_checker (.*);

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for tilt_gravity_removal
// depends on tgr_pkg and the tilt_gravity_removal rtl; predicts each untyped result
// word with its own sine table and compares every result word field by field

module tb_top;

   localparam int TABLE_DEPTH  = 256;
   localparam int QUIET_LIMIT  = 400;
   localparam int RANDOM_WORDS = 1500;
   localparam int CALM_TAIL    = 150;
   localparam int PROBE_ROWS   = 22;

   // address 0xc is past the register list
   localparam tgr_pkg::reg_index_type REG_SPARE = 2'd3;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               ff;
   } linear_word_type;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic               typed;
      linear_word_type    want;
   } probe_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic signed [15:0]             req_roll_angle = '0;
   logic signed [15:0]             req_pitch_angle = '0;
   logic signed [15:0]             req_accel_x = '0;
   logic signed [15:0]             req_accel_y = '0;
   logic signed [15:0]             req_accel_z = '0;
   logic                           rsp_valid;
   logic signed [15:0]             rsp_linear_x;
   logic signed [15:0]             rsp_linear_y;
   logic signed [15:0]             rsp_linear_z;
   logic                           rsp_free_fall;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [tgr_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]                    pwdata = '0;
   logic [31:0]                    prdata;
   logic                           pready;

   // typed expectation riding along with the word on the request ports
   logic                      row_typed = 1'b0;
   linear_word_type           row_want = '0;

   // shadow of the register file
   logic [14:0]               cfg_gravity = tgr_pkg::GRAVITY_RESET;
   logic signed [15:0]        cfg_ff_low  = tgr_pkg::FF_LOW_RESET;
   logic signed [15:0]        cfg_ff_high = tgr_pkg::FF_HIGH_RESET;

   int                        quarter_sine [0:TABLE_DEPTH];
   linear_word_type           linear_expected [$];
   int                        fail_count = 0;
   int                        quiet_cycles = 0;
   int                        words_to_go = RANDOM_WORDS;

   // directed words: saturation and threshold rows have typed results,
   // angle corner rows go through the predictor
   probe_row_type probe_rows [PROBE_ROWS] = '{
      '{16'sd9000, 16'sd0, 16'sd32767, -16'sd32768, 16'sd32767, 1'b1,
        '{16'sd32767, -16'sd32768, 16'sd32767, 1'b0}},
      '{-16'sd9000, 16'sd0, -16'sd32768, 16'sd123, 16'sd0, 1'b1,
        '{-16'sd32768, 16'sd123, 16'sd0, 1'b1}},
      '{16'sd27000, 16'sd0, -16'sd32768, 16'sd0, -16'sd2048, 1'b1,
        '{-16'sd32768, 16'sd0, -16'sd2048, 1'b0}},
      '{16'sd9000, 16'sd0, 16'sd32767, 16'sd0, -16'sd2047, 1'b1,
        '{16'sd32767, 16'sd0, -16'sd2047, 1'b1}},
      '{16'sd9000, 16'sd0, 16'sd32767, 16'sd0, 16'sd5119, 1'b1,
        '{16'sd32767, 16'sd0, 16'sd5119, 1'b1}},
      '{16'sd9000, 16'sd0, 16'sd32767, 16'sd0, 16'sd5120, 1'b1,
        '{16'sd32767, 16'sd0, 16'sd5120, 1'b0}},
      '{-16'sd9000, 16'sd12345, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1,
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0}},
      '{16'sd9000, -16'sd18000, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1,
        '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0}},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
      '{16'sd18000, 16'sd18000, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
      '{-16'sd18000, -16'sd18000, 16'sd100, -16'sd100, 16'sd1000, 1'b0, '0},
      '{16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
      '{-16'sd32768, 16'sd32767, -16'sd1, -16'sd1, -16'sd1, 1'b0, '0},
      '{16'sd0, 16'sd9000, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
      '{16'sd0, -16'sd9000, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
      '{16'sd4500, 16'sd4500, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
      '{16'sd17, 16'sd18, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
      '{16'sd8999, -16'sd8999, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
      '{16'sd18000, 16'sd0, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
      '{16'sd0, 16'sd0, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
      '{16'sd13500, -16'sd4500, -16'sd12345, 16'sd23456, 16'sd23130, 1'b0, '0},
      '{-16'sd1, 16'sd1, -16'sd21846, 16'sd21845, 16'sd0, 1'b0, '0}
   };

   tilt_gravity_removal #(
      .SINE_TABLE_DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_roll_angle  (req_roll_angle),
      .req_pitch_angle (req_pitch_angle),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .rsp_valid       (rsp_valid),
      .rsp_linear_x    (rsp_linear_x),
      .rsp_linear_y    (rsp_linear_y),
      .rsp_linear_z    (rsp_linear_z),
      .rsp_free_fall   (rsp_free_fall),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // clock: period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // quarter-wave sine in q1.15 from an eight term taylor series in q30
   function automatic void fill_quarter_sine();
      longint angle_q30;
      longint term;
      longint acc;
      longint q15;
      for (int k = 0; k <= TABLE_DEPTH; k++) begin
         angle_q30 = tgr_pkg::HALF_PI_Q30 * k / TABLE_DEPTH;
         term = angle_q30;
         acc  = angle_q30;
         for (int n = 1; n <= 7; n++) begin
            term = term * angle_q30 / 64'sd1073741824;
            term = term * angle_q30 / 64'sd1073741824;
            term = -(term / ((2 * n) * (2 * n + 1)));
            acc  = acc + term;
         end
         if (acc < 0) begin
            acc = 0;
         end
         q15 = (acc + 64'sd16384) / 64'sd32768;
         quarter_sine[k] = (q15 > 32767) ? 32767 : int'(q15);
      end
   endfunction

   // sine of an angle in hundredths of a degree, wrapped to one turn
   function automatic longint wave_at(int centideg);
      int a;
      int quad;
      int idx;
      a = centideg % tgr_pkg::ANGLE_FULL;
      if (a < 0) begin
         a = a + tgr_pkg::ANGLE_FULL;
      end
      quad = a / tgr_pkg::ANGLE_QUARTER;
      idx  = ((a % tgr_pkg::ANGLE_QUARTER) * TABLE_DEPTH + tgr_pkg::INDEX_ROUND)
             / tgr_pkg::ANGLE_QUARTER;
      if (idx > TABLE_DEPTH) begin
         idx = TABLE_DEPTH;
      end
      case (quad)
         0: return quarter_sine[idx];
         1: return quarter_sine[TABLE_DEPTH - idx];
         2: return -quarter_sine[idx];
         default: return -quarter_sine[TABLE_DEPTH - idx];
      endcase
   endfunction

   // divide by 2^sh, nearest, ties away from zero
   function automatic longint round_shift(longint v, int sh);
      longint half;
      half = longint'(1) << (sh - 1);
      if (v >= 0) begin
         return (v + half) >>> sh;
      end
      return -((-v + half) >>> sh);
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) begin
         return 16'sh7fff;
      end else if (v < -32768) begin
         return 16'sh8000;
      end
      return 16'(v);
   endfunction

   // gravity vector from tilt added to the measured axes
   function automatic linear_word_type linear_accel_of(logic signed [15:0] roll,
                                                       logic signed [15:0] pitch,
                                                       logic signed [15:0] ax,
                                                       logic signed [15:0] ay,
                                                       logic signed [15:0] az);
      linear_word_type w;
      longint g;
      longint sr;
      longint cr;
      longint sp;
      longint cp;
      g  = longint'(cfg_gravity);
      sr = wave_at(int'(roll));
      cr = wave_at(int'(roll) + tgr_pkg::ANGLE_QUARTER);
      sp = wave_at(int'(pitch));
      cp = wave_at(int'(pitch) + tgr_pkg::ANGLE_QUARTER);
      w.x  = clamp16(longint'(ax) + round_shift(g * sr, 15));
      w.y  = clamp16(longint'(ay) + round_shift(-(g * (sp * cr)), 30));
      w.z  = clamp16(longint'(az) + round_shift(-(g * (cp * cr)), 30));
      w.ff = (az > cfg_ff_low) && (az < cfg_ff_high);
      return w;
   endfunction

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // result check and prediction on accepted words, sampled at the rising edge
   always @(posedge clock) begin : result_check
      linear_word_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            if (linear_expected.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %0d %0d %0d %0d",
                        $time, rsp_linear_x, rsp_linear_y, rsp_linear_z, rsp_free_fall);
               fail_count++;
            end else begin
               want = linear_expected.pop_front();
               compare_field("linear_x", want.x, rsp_linear_x);
               compare_field("linear_y", want.y, rsp_linear_y);
               compare_field("linear_z", want.z, rsp_linear_z);
               compare_field("free_fall", want.ff, rsp_free_fall);
            end
         end
         if (start && !busy) begin
            if (row_typed) begin
               linear_expected.push_back(row_want);
            end else begin
               linear_expected.push_back(linear_accel_of(req_roll_angle, req_pitch_angle,
                                                         req_accel_x, req_accel_y,
                                                         req_accel_z));
            end
         end
         if (rsp_valid || (start && !busy) || (psel && penable && pready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // watchdog on cycles with no handshake at all
   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
      $display("%0t: no activity for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // present one word and hold it until taken
   task automatic send_word(logic signed [15:0] roll, logic signed [15:0] pitch,
                            logic signed [15:0] ax, logic signed [15:0] ay,
                            logic signed [15:0] az, logic typed, linear_word_type want);
      @(negedge clock);
      start           = 1'b1;
      req_roll_angle  = roll;
      req_pitch_angle = pitch;
      req_accel_x     = ax;
      req_accel_y     = ay;
      req_accel_z     = az;
      row_typed       = typed;
      row_want        = want;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   task automatic hold_off(int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // stop sending and let every word in flight come out
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (linear_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (tgr_pkg::LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(tgr_pkg::reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      case (idx)
         tgr_pkg::REG_GRAVITY: cfg_gravity = value[14:0];
         tgr_pkg::REG_FF_LOW:  cfg_ff_low  = value[15:0];
         tgr_pkg::REG_FF_HIGH: cfg_ff_high = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic check_reg(tgr_pkg::reg_index_type idx);
      int want;
      int got;
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = {idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      case (idx)
         tgr_pkg::REG_GRAVITY: begin
            want = cfg_gravity;
            got  = prdata[14:0];
         end
         tgr_pkg::REG_FF_LOW: begin
            want = cfg_ff_low;
            got  = $signed(prdata[15:0]);
         end
         default: begin
            want = cfg_ff_high;
            got  = $signed(prdata[15:0]);
         end
      endcase
      compare_field("register read", want, got);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic set_regs(logic [14:0] g, logic signed [15:0] lo, logic signed [15:0] hi);
      drain();
      write_reg(tgr_pkg::REG_GRAVITY, 32'(g));
      write_reg(tgr_pkg::REG_FF_LOW, 32'(lo));
      write_reg(tgr_pkg::REG_FF_HIGH, 32'(hi));
      check_reg(tgr_pkg::REG_GRAVITY);
      check_reg(tgr_pkg::REG_FF_LOW);
      check_reg(tgr_pkg::REG_FF_HIGH);
   endtask

   // angles mostly in range, some near quadrant edges, some past +-180 degrees
   function automatic logic signed [15:0] pick_angle();
      int a;
      case ($urandom_range(0, 9))
         0: a = int'($urandom_range(0, 65535)) - 32768;
         1: a = tgr_pkg::ANGLE_QUARTER * int'($urandom_range(0, 4))
                - tgr_pkg::ANGLE_HALF + int'($urandom_range(0, 40)) - 20;
         default: a = int'($urandom_range(0, tgr_pkg::ANGLE_FULL)) - tgr_pkg::ANGLE_HALF;
      endcase
      return 16'(a);
   endfunction

   function automatic logic signed [15:0] pick_accel();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 2))
               0: return -16'sd32768;
               1: return 16'sd32767;
               default: return 16'sd0;
            endcase
         end
         1, 2: return 16'($urandom);
         default: return 16'(int'($urandom_range(0, 24000)) - 12000);
      endcase
   endfunction

   // random words with idle bursts; idling switches on and off in blocks
   task automatic send_random(int count);
      logic signed [15:0] az;
      bit idle_on;
      idle_on = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            idle_on = $urandom_range(0, 1);
         end
         if (idle_on && words_to_go > CALM_TAIL && $urandom_range(0, 5) == 0) begin
            hold_off($urandom_range(1, 15));
         end
         az = pick_accel();
         if ($urandom_range(0, 4) == 0) begin
            az = 16'(int'($urandom_range(0, 1) ? cfg_ff_low : cfg_ff_high)
                     + int'($urandom_range(0, 4)) - 2);
         end
         send_word(pick_angle(), pick_angle(), pick_accel(), pick_accel(), az, 1'b0, '0);
         words_to_go--;
      end
   endtask

   // stimulus
   initial begin
      fill_quarter_sine();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed words under reset settings
      for (int r = 0; r < PROBE_ROWS; r++) begin
         send_word(probe_rows[r].roll, probe_rows[r].pitch, probe_rows[r].ax,
                   probe_rows[r].ay, probe_rows[r].az, probe_rows[r].typed,
                   probe_rows[r].want);
      end
      send_random(250);

      // strongest gravity, widest free-fall window
      set_regs(15'h7fff, -16'sd32768, 16'sd32767);
      send_random(250);

      // no gravity, thresholds crossed so the flag stays low
      set_regs(15'd0, 16'sd32767, -16'sd32768);
      write_reg(REG_SPARE, 32'h0000_1234);
      check_reg(tgr_pkg::REG_GRAVITY);
      send_random(250);

      // random settings, with a full drain in the middle
      set_regs(15'($urandom), 16'($urandom), 16'($urandom));
      send_random(100);
      drain();
      send_random(150);

      // smallest gravity, equal thresholds
      set_regs(15'd1, 16'sd0, 16'sd0);
      send_random(250);

      // back to reset values; the last 150 words run without idling
      set_regs(tgr_pkg::GRAVITY_RESET, tgr_pkg::FF_LOW_RESET, tgr_pkg::FF_HIGH_RESET);
      send_random(250);

      @(negedge clock);
      start = 1'b0;
      while (linear_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (tgr_pkg::LATENCY + 5) @(posedge clock);
      if (linear_expected.size() != 0) begin
         $display("%0t: %0d result words never arrived", $time, linear_expected.size());
      end
      if (fail_count == 0 && linear_expected.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/tgr_pkg.sv
rtl/core/tgr_sine_lookup.sv
rtl/core/tilt_gravity_removal.sv
rtl/core/tgr_checker.sv
test/tb_top.sv
